// ----- src/hmis_pkg.sv -----
// Shared types and constants for the hybrid merge insertion sorter.
`default_nettype none

package hmis_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned THRESH_W = 7;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned PADDR_W  = 3;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(16);

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0
    } t_reg_idx;

    typedef enum logic [0:0] {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    typedef struct packed {
        logic ins;
        logic shl;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- src/hmis_cell.sv -----
// One sorting cell: holds a value, inserts in order or shifts towards the head.
`default_nettype none

module hmis_cell (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire hmis_pkg::t_cell_ctrl               i_ctrl,
    input  wire logic signed [hmis_pkg::DATA_W-1:0] i_new,
    input  wire logic signed [hmis_pkg::DATA_W-1:0] i_left_val,
    input  wire                                     i_left_valid,
    input  wire                                     i_left_take,
    input  wire logic signed [hmis_pkg::DATA_W-1:0] i_right_val,
    input  wire                                     i_right_valid,
    output logic signed [hmis_pkg::DATA_W-1:0]      o_val,
    output logic                                    o_valid,
    output logic                                    o_take
);
    import hmis_pkg::*;

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     r_valid;
    logic                     n_valid;

    // empty cells act as +infinity, so the take flags stay monotonic
    assign o_take = !r_valid || (i_new < r_val);

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctrl.ins && o_take) begin
            if (i_left_take) begin
                n_val   = i_left_val;
                n_valid = i_left_valid;
            end else begin
                n_val   = i_new;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.shl) begin
            n_val   = i_right_val;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ----- src/hybrid_merge_insertion_sorter.sv -----
// Top level of the run sorter: cell row, load/drain control and register port.
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one signed value per beat,
//   i_last_item closing the run. Each beat is inserted in order into a row of
//   MAX_ELEMENTS cells; beats beyond capacity are dropped and the run is
//   marked.
//   On the closing beat the block stops taking input and drains the row,
//   smallest first, one result per cycle unless the receiver stalls, through
//   an output register (o_out_valid / i_out_stall). The final result carries
//   o_last_result and every result of a run that lost beats carries o_dropped.
//   While loading, input beats are taken back to back; the drain is paced
//   by the row's shift towards the head. After the closing beat the state
//   register moves to drain, then the head value loads the output register.
//   While the receiver stalls, the output register holds and the drain
//   pauses; input stays stalled until the last result is taken into the
//   output register.
//   Reset empties the row, clears the run state and sets the insertion
//   threshold register (byte address 0) to 16; the threshold has no effect
//   on the order emitted.
`default_nettype none

module hybrid_merge_insertion_sorter #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [hmis_pkg::DATA_W-1:0] i_value,
    input  wire                                     i_last_item,
    output logic                                    o_out_valid,
    input  wire                                     i_out_stall,
    output logic signed [hmis_pkg::DATA_W-1:0]      o_sorted_value,
    output logic                                    o_last_result,
    output logic                                    o_dropped,
    input  wire                                     psel,
    input  wire                                     penable,
    input  wire                                     pwrite,
    input  wire logic [hmis_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [hmis_pkg::CFG_W-1:0]         pwdata,
    output logic [hmis_pkg::CFG_W-1:0]              prdata,
    output logic                                    pready
);
    import hmis_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_ovf;
    logic                     n_ovf;
    logic [THRESH_W-1:0]      r_thresh;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_val;
    logic                     r_out_last;
    logic                     r_out_drop;

    logic                     w_in_acc;
    logic                     w_full;
    logic                     w_load_out;
    logic                     w_cfg_wr;
    t_reg_idx                 w_reg_idx;
    t_cell_ctrl               w_ctrl;

    logic signed [DATA_W-1:0] w_val   [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]  w_valid;
    logic [MAX_ELEMENTS-1:0]  w_take;

    // cell row
    for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
        logic signed [DATA_W-1:0] w_lv;
        logic                     w_lvld;
        logic                     w_ltk;
        logic signed [DATA_W-1:0] w_rv;
        logic                     w_rvld;

        if (i == 0) begin : g_head
            assign w_lv   = '0;
            assign w_lvld = 1'b0;
            assign w_ltk  = 1'b0;
        end else begin : g_mid
            assign w_lv   = w_val[i-1];
            assign w_lvld = w_valid[i-1];
            assign w_ltk  = w_take[i-1];
        end

        if (i == MAX_ELEMENTS - 1) begin : g_tail
            assign w_rv   = '0;
            assign w_rvld = 1'b0;
        end else begin : g_body
            assign w_rv   = w_val[i+1];
            assign w_rvld = w_valid[i+1];
        end

        hmis_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new         (i_value),
            .i_left_val    (w_lv),
            .i_left_valid  (w_lvld),
            .i_left_take   (w_ltk),
            .i_right_val   (w_rv),
            .i_right_valid (w_rvld),
            .o_val         (w_val[i]),
            .o_valid       (w_valid[i]),
            .o_take        (w_take[i])
        );
    end

    assign w_full     = (r_count == CNT_W'(MAX_ELEMENTS));
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_load_out = (r_state == ST_DRAIN) && (r_count != '0)
                        && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_last_item) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_count == '0 || (w_load_out && r_count == CNT_W'(1))) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_ctrl     = '0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                w_ctrl.ins = i_in_valid && !w_full;
            end
            ST_DRAIN: begin
                w_ctrl.shl = w_load_out;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_load_out) begin
            n_count = r_count - CNT_W'(1);
        end
        if (w_in_acc && w_full) begin
            n_ovf = 1'b1;
        end else if (r_state == ST_DRAIN && n_state == ST_LOAD) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_val  <= w_val[0];
            r_out_last <= (r_count == CNT_W'(1));
            r_out_drop <= r_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_val;
    assign o_last_result  = r_out_last;
    assign o_dropped      = r_out_drop;

    // register port
    assign w_reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_THRESHOLD: r_thresh <= pwdata[THRESH_W-1:0];
                default:       r_thresh <= r_thresh;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            REG_THRESHOLD: prdata = CFG_W'(r_thresh);
            default:       prdata = '0;
        endcase
    end

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("stored count disagrees with occupied cells");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ELEMENTS))
        else $error("count above capacity");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out && r_count == CNT_W'(1) |=> r_state == ST_LOAD && r_count == '0)
        else $error("last result while cells still hold data");

    a_drop_marks_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_full |=> r_ovf)
        else $error("beat past capacity not recorded");

    a_head_is_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] && w_valid[1 % MAX_ELEMENTS] && (MAX_ELEMENTS > 1)
        |-> w_val[0] <= w_val[1 % MAX_ELEMENTS])
        else $error("head cell not the smallest");

endmodule

`default_nettype wire
